// ----- hdl/iptd_pkg.sv -----
// ----------------------------------------------------------------------------
// iptd_pkg
// Shared constants, FSM state type and controller/datapath interface structs
// for the incremental trial-division prime tester.
// ----------------------------------------------------------------------------
`default_nettype none

package iptd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_WIDTH   = 31;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int BIT_CNT_W   = $clog2(NUM_WIDTH);

  // entry zero of the table is fixed to this value
  localparam logic [NUM_WIDTH-1:0] SEED_PRIME = NUM_WIDTH'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_cand;   // latch candidate, reset walk index and prime flag
    logic rd_en;       // read table entry at walk index
    logic inc_idx;     // advance walk index
    logic div_start;   // clear remainder, load dividend
    logic div_step;    // one restoring-division bit
    logic mark_comp;   // candidate found composite
    logic commit;      // append if prime, load result register
  } cmd_t;

  typedef struct packed {
    logic idx_at_end;  // walk index reached table fill count
    logic p_above;     // current entry above half the candidate
    logic p_zero;      // current entry is zero
    logic div_last;    // last division bit in progress
    logic rem_zero;    // remainder is zero
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage

`default_nettype wire

// ----- hdl/iptd_ctrl.sv -----
// ----------------------------------------------------------------------------
// iptd_ctrl
// Sequencer for the table walk: fetch entry, bound check, bit-serial
// remainder, then commit of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module iptd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire iptd_pkg::sts_t sts,
  output iptd_pkg::cmd_t      cmd
);
  import iptd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_cand = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts.idx_at_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.p_above) begin
          state_next = S_FINISH;
        end else if (sts.p_zero) begin
          // zero entry never divides
          cmd.inc_idx = 1'b1;
          state_next  = S_FETCH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.rem_zero) begin
          cmd.mark_comp = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = S_FETCH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/iptd_dp.sv -----
// ----------------------------------------------------------------------------
// iptd_dp
// Datapath: prime table memory, walk index, fill count, restoring remainder
// unit and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module iptd_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [iptd_pkg::NUM_WIDTH-1:0]  candidate,
  input  wire iptd_pkg::cmd_t                  cmd,
  output iptd_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 is_prime,
  output logic                                 stored,
  output logic                                 table_full,
  output logic [iptd_pkg::CNT_W-1:0]           prime_count
);
  import iptd_pkg::*;

  logic [NUM_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [NUM_WIDTH-1:0] mem_q;
  logic                 rd_seed;

  logic [NUM_WIDTH-1:0] cand;
  logic [CNT_W-1:0]     idx;
  logic [CNT_W-1:0]     count_held;
  logic                 prime_flag;

  logic [NUM_WIDTH-1:0] rem;
  logic [NUM_WIDTH-1:0] dvd;
  logic [BIT_CNT_W-1:0] bit_cnt;

  logic [NUM_WIDTH-1:0] p_word;
  logic [NUM_WIDTH-1:0] half;
  logic [NUM_WIDTH:0]   trial;
  logic [NUM_WIDTH:0]   trial_sub;
  logic                 full;
  logic                 do_store;
  logic                 out_free;

  assign p_word    = rd_seed ? SEED_PRIME : mem_q;
  assign half      = cand >> 1;
  assign trial     = {rem, dvd[NUM_WIDTH-1]};
  assign trial_sub = trial - {1'b0, p_word};
  assign full      = (count_held == CNT_W'(TABLE_DEPTH));
  assign do_store  = prime_flag && !full;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    sts            = '0;
    sts.idx_at_end = (idx >= count_held);
    sts.p_above    = (p_word > half);
    sts.p_zero     = (p_word == '0);
    sts.div_last   = (bit_cnt == BIT_CNT_W'(NUM_WIDTH - 1));
    sts.rem_zero   = (rem == '0);
    sts.out_free   = out_free;
  end

  // table memory; entry zero is never written and reads as the seed
  always_ff @(posedge clk) begin
    if (cmd.commit && do_store) begin
      mem[count_held[ADDR_W-1:0]] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q   <= mem[idx[ADDR_W-1:0]];
      rd_seed <= (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cand) begin
      cand <= candidate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      prime_flag <= 1'b1;
      count_held <= CNT_W'(1);
    end else begin
      if (cmd.load_cand) begin
        idx        <= '0;
        prime_flag <= 1'b1;
      end else if (cmd.inc_idx) begin
        idx <= idx + CNT_W'(1);
      end
      if (cmd.mark_comp) begin
        prime_flag <= 1'b0;
      end
      if (cmd.commit && do_store) begin
        count_held <= count_held + CNT_W'(1);
      end
    end
  end

  // one quotient bit per cycle, only the remainder is kept
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= '0;
      dvd     <= cand;
      bit_cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial_sub[NUM_WIDTH]) begin
        rem <= trial_sub[NUM_WIDTH-1:0];
      end else begin
        rem <= trial[NUM_WIDTH-1:0];
      end
      dvd     <= dvd << 1;
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      is_prime    <= prime_flag;
      stored      <= do_store;
      table_full  <= full;
      prime_count <= do_store ? count_held + CNT_W'(1) : count_held;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/incremental_prime_trial_divider_core.sv -----
// ----------------------------------------------------------------------------
// incremental_prime_trial_divider_core
// Tests each candidate by trial division against the primes found so far
// and appends new primes to an on-chip table.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_stall    candidate
//   out      source     out_valid/out_stall  is_prime, stored, table_full,
//                                            prime_count
//
// Per candidate the walk fetches each entry, checks it against the bound,
// skips zero entries, divides by the rest and tests the remainder, then
// commits the result; the bit-serial remainder unit (one bit per cycle)
// dominates. Entries above half the candidate end the walk.
// Reset: no clearing pass; entry zero is the fixed seed 2, fill count 1.
// in_stall is high while a candidate is in work. A finished result waits
// for a stalled output register before it is committed.
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_prime_trial_divider_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [iptd_pkg::NUM_WIDTH-1:0]  candidate,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 is_prime,
  output logic                                 stored,
  output logic                                 table_full,
  output logic [iptd_pkg::CNT_W-1:0]           prime_count
);
  import iptd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  iptd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iptd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .candidate   (candidate),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_prime    (is_prime),
    .stored      (stored),
    .table_full  (table_full),
    .prime_count (prime_count)
  );

endmodule

`default_nettype wire

// ----- hdl/iptd_chk.sv -----
// ----------------------------------------------------------------------------
// iptd_chk
// Port-level checks for the prime tester, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iptd_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            is_prime,
  input wire logic                            stored,
  input wire logic                            table_full,
  input wire logic [iptd_pkg::CNT_W-1:0]      prime_count
);
  import iptd_pkg::*;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a request in work blocks the next one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_store_prime: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stored && (!is_prime || table_full)))
    else $error("store without room or without prime");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prime_count != '0) && (prime_count <= CNT_W'(TABLE_DEPTH)))
    else $error("prime count out of range");

  // full flag means the count sits at the table depth
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> prime_count == CNT_W'(TABLE_DEPTH))
    else $error("full flag with short count");

endmodule

bind incremental_prime_trial_divider_core iptd_chk u_iptd_chk (.*);

`default_nettype wire
